### rtl/segment_allocator_fit_policies_top_defines.svh
// Assertion macros shared by the segment allocator RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef SEGMENT_ALLOCATOR_FIT_POLICIES_TOP_DEFINES_SVH
`define SEGMENT_ALLOCATOR_FIT_POLICIES_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define SAFP_ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SAFP_ASSERT_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SAFP_ASSERT_CLK(label, clk, rst, prop, msg)
`define SAFP_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

### rtl/safp_pkg.sv
// Shared types and codes for the segment allocator.
// Used by the controller, the datapath and the top level.
package safp_pkg;

  localparam logic [2:0] CMD_PLACE   = 3'd0;
  localparam logic [2:0] CMD_ALLOC   = 3'd1;
  localparam logic [2:0] CMD_RELEASE = 3'd2;
  localparam logic [2:0] CMD_COMPACT = 3'd3;
  localparam logic [2:0] CMD_LIST    = 3'd4;

  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_WORST = 2'd1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // Capture the command and reset the scan.
    logic scan;      // Examine the table entry at the scan index.
    logic decide;    // Pick the target after the scan.
    logic shift_up;  // Move one entry up for an insert.
    logic write_new; // Write the new entry at the insert position.
    logic squeeze;   // Release step: copy kept entries down.
    logic compact;   // Compact step on the scan entry.
    logic list;      // Read the scan entry for a listing.
  } safp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;  // Scan index has reached the count.
    logic rd_valid;   // Registered read data is for the scan entry.
    logic found;      // A target was chosen.
    logic shift_done; // Shift reached the insert position.
  } safp_stat_t;

endpackage

### rtl/safp_datapath.sv
// Datapath of the segment allocator: segment table memories, scan and fit logic.
// Depends on safp_pkg.
module safp_datapath
  import safp_pkg::*;
#(
  parameter int MAX_SEGMENTS = 32,
  parameter int ADDR_BITS    = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  safp_cmd_t            cmd,
  output safp_stat_t           stat,
  input  logic [2:0]           op,
  input  logic [15:0]          owner,
  input  logic [15:0]          start_addr,
  input  logic [15:0]          length,
  input  logic [1:0]           policy,
  input  logic [15:0]          capacity,
  output logic                 res_ok,
  output logic                 res_empty,
  output logic [15:0]          rd_start,
  output logic [15:0]          rd_length,
  output logic [15:0]          rd_owner,
  output logic                 rd_last
);

  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int EW = ADDR_BITS + 1;

  // Table memories.
  logic [ADDR_BITS-1:0] mem_start [MAX_SEGMENTS];
  logic [ADDR_BITS-1:0] mem_len   [MAX_SEGMENTS];
  logic [15:0]          mem_own   [MAX_SEGMENTS];

  logic [CW-1:0]        count;
  logic [CW-1:0]        idx;      // scan read index
  logic [CW-1:0]        widx;     // write index for release
  logic [CW-1:0]        pos;      // insert position
  logic [CW-1:0]        sidx;     // shift index
  logic                 rv;       // read data valid
  logic [CW-1:0]        ridx;     // index of registered read data
  logic [ADDR_BITS-1:0] r_start, r_len;
  logic [15:0]          r_own;
  logic [EW-1:0]        prev_end;
  logic                 found;
  logic [EW-1:0]        best_gap, best_lo;
  logic [CW-1:0]        best_pos;
  logic                 done_scan;
  logic                 ok;
  logic [ADDR_BITS-1:0] new_start;
  logic [2:0]           c_op;
  logic [15:0]          c_own;
  logic [ADDR_BITS-1:0] c_x, c_y;
  logic [1:0]           c_pol;
  logic                 fixed_hit;

  // Combinational gap evaluation on the registered entry.
  logic [EW-1:0] gap, e_fix, r_end, tail_gap, cap_ext;
  logic          better, tail_fits, full;
  always_comb begin
    r_end    = {1'b0, r_start} + {1'b0, r_len};
    gap      = ({1'b0, r_start} > prev_end) ? {1'b0, r_start} - prev_end : '0;
    better   = !found || (c_pol == POL_WORST && gap > best_gap) ||
               (c_pol[1] && gap < best_gap);
    e_fix    = {1'b0, c_x} + {1'b0, c_y};
    cap_ext  = EW'(capacity);
    tail_fits = (prev_end + {1'b0, c_y}) <= cap_ext;
    tail_gap = cap_ext - prev_end;
    full     = (count == CW'(MAX_SEGMENTS));
  end

  assign stat.scan_done  = done_scan;
  assign stat.rd_valid   = rv;
  assign stat.found      = ok;
  assign stat.shift_done = (sidx == pos);

  // Read port.
  always_ff @(posedge clk) begin
    r_start <= mem_start[idx[IW-1:0]];
    r_len   <= mem_len[idx[IW-1:0]];
    r_own   <= mem_own[idx[IW-1:0]];
    ridx    <= idx;
  end

  // Write port and control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      rv    <= 1'b0;
    end else begin
      rv <= 1'b0;
      if (cmd.load) begin
        c_op <= op; c_own <= owner; c_x <= ADDR_BITS'(start_addr);
        c_y <= ADDR_BITS'(length); c_pol <= policy;
        idx <= '0; widx <= '0; prev_end <= '0; found <= 1'b0;
        best_gap <= '0; best_lo <= '0; best_pos <= '0; done_scan <= 1'b0;
        fixed_hit <= 1'b0; ok <= 1'b0;
      end
      if (cmd.scan || cmd.squeeze || cmd.compact || cmd.list) begin
        if (!rv) begin
          // Issue a read of the current index.
          if (idx >= count) done_scan <= 1'b1;
          else rv <= 1'b1;
        end else begin
          idx <= idx + 1'b1;
          prev_end <= r_end;
          if (cmd.scan) begin
            if (c_op == CMD_PLACE) begin
              if ({1'b0, r_start} < e_fix) begin
                best_pos <= ridx + 1'b1;
                fixed_hit <= r_end > {1'b0, c_x};
              end
            end else if (!(found && c_pol == POL_FIRST) && gap >= {1'b0, c_y} && better) begin
              found <= 1'b1; best_gap <= gap; best_lo <= prev_end; best_pos <= ridx;
            end
          end
          if (cmd.squeeze && r_own != c_own) begin
            mem_start[widx[IW-1:0]] <= r_start;
            mem_len[widx[IW-1:0]]   <= r_len;
            mem_own[widx[IW-1:0]]   <= r_own;
            widx <= widx + 1'b1;
          end
          if (cmd.compact) begin
            if ({1'b0, r_start} > prev_end) begin
              mem_start[ridx[IW-1:0]] <= prev_end[ADDR_BITS-1:0];
              prev_end <= prev_end + {1'b0, r_len};
            end
          end
        end
      end
      if (cmd.decide) begin
        if (c_op == CMD_PLACE) begin
          ok <= !full && e_fix <= cap_ext && !fixed_hit;
          new_start <= c_x;
          pos <= best_pos;
        end else begin
          if (tail_fits && (!found || (c_pol == POL_WORST && tail_gap > best_gap) ||
                            (c_pol[1] && tail_gap < best_gap))) begin
            ok <= !full; new_start <= prev_end[ADDR_BITS-1:0]; pos <= count;
          end else begin
            ok <= !full && found; new_start <= best_lo[ADDR_BITS-1:0]; pos <= best_pos;
          end
        end
        sidx <= count;
      end
      if (cmd.shift_up) begin
        mem_start[sidx[IW-1:0]] <= mem_start[IW'(sidx - 1'b1)];
        mem_len[sidx[IW-1:0]]   <= mem_len[IW'(sidx - 1'b1)];
        mem_own[sidx[IW-1:0]]   <= mem_own[IW'(sidx - 1'b1)];
        sidx <= sidx - 1'b1;
      end
      if (cmd.write_new) begin
        mem_start[pos[IW-1:0]] <= new_start;
        mem_len[pos[IW-1:0]]   <= c_y;
        mem_own[pos[IW-1:0]]   <= c_own;
        count <= count + 1'b1;
      end
      if (cmd.squeeze && done_scan) count <= widx;
    end
  end

  assign res_ok    = ok;
  assign res_empty = (count == '0);
  assign rd_start  = 16'(r_start);
  assign rd_length = 16'(r_len);
  assign rd_owner  = r_own;
  assign rd_last   = (ridx + 1'b1 == count);

endmodule

### rtl/safp_ctrl.sv
// Controller state machine of the segment allocator.
// Depends on safp_pkg and the assertion macro header.
`include "segment_allocator_fit_policies_top_defines.svh"
module safp_ctrl
  import safp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [2:0]  cmd_in,
  output logic        busy,
  output safp_cmd_t   cmd,
  input  safp_stat_t  stat,
  output logic        out_fire,
  output logic        out_entry,
  output logic        out_err
);

  localparam logic [3:0] S_IDLE = 4'd0, S_SCAN = 4'd1, S_DECIDE = 4'd2, S_CHECK = 4'd3,
                         S_SHIFT = 4'd4, S_WRITE = 4'd5, S_SQZ = 4'd6, S_CMP = 4'd7,
                         S_LIST = 4'd8, S_DONE = 4'd9;

  logic [3:0] state, state_next;
  logic [2:0] op;

  // Next-state logic.
  always_comb begin
    state_next = state;
    cmd = '0;
    out_fire = 1'b0; out_entry = 1'b0; out_err = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          case (cmd_in)
            CMD_PLACE, CMD_ALLOC: state_next = S_SCAN;
            CMD_RELEASE: state_next = S_SQZ;
            CMD_COMPACT: state_next = S_CMP;
            CMD_LIST: state_next = S_LIST;
            default: state_next = S_DONE;
          endcase
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: state_next = stat.found ? S_SHIFT : S_DONE;
      S_SHIFT: begin
        if (stat.shift_done) state_next = S_WRITE;
        else cmd.shift_up = 1'b1;
      end
      S_WRITE: begin
        cmd.write_new = 1'b1;
        state_next = S_DONE;
      end
      S_SQZ: begin
        cmd.squeeze = 1'b1;
        if (stat.scan_done) state_next = S_DONE;
      end
      S_CMP: begin
        cmd.compact = 1'b1;
        if (stat.scan_done) state_next = S_DONE;
      end
      S_LIST: begin
        cmd.list = 1'b1;
        out_fire = stat.rd_valid;
        out_entry = 1'b1;
        if (stat.scan_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        // A listing has already sent all of its items from the list state.
        out_fire = (op != CMD_LIST);
        out_err = (op == CMD_PLACE || op == CMD_ALLOC) ? !stat.found :
                  (op == CMD_RELEASE || op == CMD_COMPACT || op == CMD_LIST) ? 1'b0 : 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
      if (cmd.load) op <= cmd_in;
    end
  end

  assign busy = (state != S_IDLE);

  `SAFP_ASSERT_CLK(a_load_idle, clk, rst, cmd.load |-> !busy, "load outside idle")
  `SAFP_ASSERT_CLK(a_done_idle, clk, rst, state == S_DONE |=> state == S_IDLE, "done stuck")
  `SAFP_ASSERT_CLK(a_one_op, clk, rst, $onehot0(cmd), "more than one datapath command")
  `SAFP_ASSERT_NORST(a_rst_idle, clk, rst |=> !busy, "busy after reset")

endmodule

### rtl/segment_allocator_fit_policies_top.sv
// Segment allocator with first, worst and best fit over an address-sorted table.
// An insert shifts up the entries above its position (at most N of N held) before writing the
// new entry; a refused insert, a release, a compact and an unknown command each give a status
// item. A listing gives one item per entry and reads each entry only after the last one's data
// is taken; busy falls as the status item appears; results cannot be stalled.
// Synchronous reset empties the table and sets capacity to 65535.
module segment_allocator_fit_policies_top
  import safp_pkg::*;
#(
  parameter int MAX_SEGMENTS = 32,
  parameter int ADDR_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  cmd,
  input  logic [15:0] owner,
  input  logic [15:0] start_addr,
  input  logic [15:0] length,
  input  logic [1:0]  policy,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output logic        result_strobe,
  output logic        status,
  output logic        entry_valid,
  output logic [15:0] entry_start,
  output logic [15:0] entry_length,
  output logic [15:0] entry_owner,
  output logic        last
);

  safp_cmd_t  dcmd;
  safp_stat_t stat;
  logic [15:0] capacity;
  logic fire, ent, err, ok, empty, rlast;
  logic [15:0] rs, rl, ro;

  // Capacity register.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) capacity <= 16'hFFFF;
    else if (cfg_valid) capacity <= cfg_data;
  end

  safp_ctrl u_ctrl (.clk, .rst, .start, .cmd_in(cmd), .busy, .cmd(dcmd), .stat,
                    .out_fire(fire), .out_entry(ent), .out_err(err));

  safp_datapath #(.MAX_SEGMENTS(MAX_SEGMENTS), .ADDR_BITS(ADDR_BITS)) u_dp (
    .clk, .rst, .cmd(dcmd), .stat, .op(cmd), .owner, .start_addr, .length, .policy,
    .capacity, .res_ok(ok), .res_empty(empty), .rd_start(rs), .rd_length(rl),
    .rd_owner(ro), .rd_last(rlast));

  // Result register: listings give one item per entry (one empty item for an empty table), else one status item.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= fire && !(ent && empty && !stat.rd_valid) ? 1'b1 :
                       (ent && empty && stat.scan_done);
      if (ent && stat.rd_valid) begin
        status <= 1'b0; entry_valid <= 1'b1; entry_start <= rs;
        entry_length <= rl; entry_owner <= ro; last <= rlast;
      end else begin
        status <= ent ? 1'b0 : err; entry_valid <= 1'b0; entry_start <= '0;
        entry_length <= '0; entry_owner <= '0; last <= 1'b1;
      end
    end
  end

endmodule
